/* hw/rtl/linear_probe_hash_table_core_macros.svh */
// assertion macros for the linear probe hash table core
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LPHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LPHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lpht_pkg.sv */
// types and codes shared by the linear probe hash table core
`default_nettype none

package lpht_pkg;

    localparam int KEY_W   = 31;
    localparam int VALUE_W = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] ST_NEW      = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_DELETED  = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;
    localparam logic [2:0] ST_FOUND    = 3'd5;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_LIVE    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    localparam logic signed [VALUE_W-1:0] NO_VALUE = -32'sd1;

    typedef struct packed {
        logic [1:0]                op;
        logic [KEY_W-1:0]          lookup_key;
        logic signed [VALUE_W-1:0] new_value;
    } t_req;

    typedef struct packed {
        logic [2:0]                status;
        logic signed [VALUE_W-1:0] read_value;
        logic [7:0]                entry_count;
    } t_rsp;

    typedef struct packed {
        logic [1:0]                mark;
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
    } t_slot;

endpackage

`default_nettype wire

/* hw/rtl/linear_probe_hash_table_core.sv */
// top level of the linear probe hash table core
`default_nettype none

`include "linear_probe_hash_table_core_macros.svh"

// Open-addressing key/value table with linear probing. A transaction is taken
// when start is high and busy is low; its result appears on o_rsp with o_done
// high for exactly one cycle and cannot be held off. After reset the block
// clears the slot memory, one slot per cycle, and holds busy high until every
// slot is cleared. An unused op code answers in the cycle after acceptance.
// Every other transaction first reduces the key modulo TABLE_SIZE by
// reciprocal multiplication (key, quotient and remainder registers), then
// walks the probe path through the single read port of the slot memory, one
// slot per cycle, and writes back at most once. The result strobe follows the
// last of the slots probed, from 1 up to TABLE_SIZE; busy drops in the strobe
// cycle, so the next transaction may be taken right away.
module linear_probe_hash_table_core
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_done,
    output t_rsp      o_rsp
);

    localparam int AW = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;
    localparam int LW = $clog2(TABLE_SIZE + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_pos;
    logic [AW-1:0] r_cnt;
    logic [LW-1:0] r_live;
    logic          r_done;
    t_req          r_req;
    t_rsp          r_rsp;

    logic          mod_start;
    logic          mod_done;
    logic [AW-1:0] mod_rem;

    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    t_slot         mem_rd_data;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    t_slot         mem_wr_data;

    logic [AW-1:0] pos_nxt;
    logic          is_live;
    logic          key_eq;
    logic          last_probe;
    logic          fin;
    logic [2:0]    fin_status;
    logic [LW-1:0] n_live;

    function automatic logic [7:0] sat_cnt(input logic [LW-1:0] c);
        logic [31:0] wide;
        wide = 32'(c);
        return (wide > 32'd255) ? 8'hFF : wide[7:0];
    endfunction

    assign mod_start = start && (r_state == S_IDLE) && (i_req.op != OP_NONE);

    lpht_mod #(
        .TABLE_SIZE (TABLE_SIZE),
        .AW         (AW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (i_req.lookup_key),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    lpht_mem #(
        .DEPTH (TABLE_SIZE),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    assign pos_nxt    = (r_pos == AW'(TABLE_SIZE - 1)) ? '0 : r_pos + 1'b1;
    assign is_live    = (mem_rd_data.mark == MARK_LIVE);
    assign key_eq     = (mem_rd_data.key == r_req.lookup_key);
    assign last_probe = (r_cnt == AW'(TABLE_SIZE - 1));

    // probe decision for the slot whose read data is back this cycle
    always_comb begin
        fin        = 1'b0;
        fin_status = ST_MISSING;
        n_live     = r_live;
        unique case (r_req.op)
            OP_INSERT: begin
                if (!is_live || key_eq) begin
                    fin        = 1'b1;
                    fin_status = is_live ? ST_REPLACED : ST_NEW;
                    if (!is_live) begin
                        n_live = r_live + 1'b1;
                    end
                end else if (last_probe) begin
                    fin        = 1'b1;
                    fin_status = ST_FULL;
                end
            end
            OP_DELETE: begin
                if (is_live && key_eq) begin
                    fin        = 1'b1;
                    fin_status = ST_DELETED;
                    if (r_live != '0) begin
                        n_live = r_live - 1'b1;
                    end
                end else if (mem_rd_data.mark == MARK_EMPTY || last_probe) begin
                    fin = 1'b1;
                end
            end
            default: begin
                if (is_live && key_eq) begin
                    fin        = 1'b1;
                    fin_status = ST_FOUND;
                end else if (mem_rd_data.mark == MARK_EMPTY || last_probe) begin
                    fin = 1'b1;
                end
            end
        endcase
    end

    // memory port control
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = pos_nxt;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_pos;
        mem_wr_data = '{mark: MARK_LIVE, key: r_req.lookup_key, value: r_req.new_value};
        unique case (r_state)
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr_addr;
                mem_wr_data = '{mark: MARK_EMPTY, key: '0, value: '0};
            end
            S_HASH: begin
                mem_rd_en   = mod_done;
                mem_rd_addr = mod_rem;
            end
            S_PROBE: begin
                // next slot is read ahead; it is ignored once the walk stops
                mem_rd_en = 1'b1;
                if (fin && fin_status == ST_NEW) begin
                    mem_wr_en = 1'b1;
                end else if (fin && fin_status == ST_REPLACED) begin
                    mem_wr_en = 1'b1;
                end else if (fin && fin_status == ST_DELETED) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = '{mark: MARK_DELETED, key: mem_rd_data.key,
                                    value: mem_rd_data.value};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_live     <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(TABLE_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_req <= i_req;
                        if (i_req.op == OP_NONE) begin
                            r_done <= 1'b1;
                            r_rsp  <= '{status: ST_MISSING, read_value: NO_VALUE,
                                        entry_count: sat_cnt(r_live)};
                        end else begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (mod_done) begin
                        r_pos   <= mod_rem;
                        r_cnt   <= '0;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (fin) begin
                        r_live  <= n_live;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        r_rsp   <= '{status: fin_status,
                                     read_value: (fin_status == ST_FOUND) ?
                                                 mem_rd_data.value : NO_VALUE,
                                     entry_count: sat_cnt(n_live)};
                    end else begin
                        r_pos <= pos_nxt;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `LPHT_ASSERT_NEXT(a_walk_no_early_result, i_clk, i_rst_n, start && !busy && i_req.op != OP_NONE, busy && !o_done, "probe transaction answered in the cycle after acceptance")
    `LPHT_ASSERT_NOW(a_value_only_when_found, i_clk, i_rst_n, o_done && o_rsp.status != ST_FOUND, o_rsp.read_value == NO_VALUE, "read value set on a result other than found")
    `LPHT_ASSERT_NOW(a_count_bounded, i_clk, i_rst_n, o_done, 32'(o_rsp.entry_count) <= TABLE_SIZE, "entry count above table size")

endmodule

`default_nettype wire

/* hw/rtl/lpht_mod.sv */
// key reduction modulo the table size by reciprocal multiplication
`default_nettype none

module lpht_mod
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 128,
    parameter int AW         = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [KEY_W-1:0] i_key,
    output logic                  o_done,
    output logic [AW-1:0]         o_rem
);

    // rounded-up reciprocal, exact quotient for every key of KEY_W bits
    localparam int          LG      = $clog2(TABLE_SIZE);
    localparam int          SHIFT   = KEY_W + LG;
    localparam logic [63:0] RECIP_W = ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1)
                                      / 64'(TABLE_SIZE);
    localparam logic [31:0] RECIP   = RECIP_W[31:0];

    logic               r_stage1;
    logic               r_stage2;
    logic               r_done;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_quo;
    logic [AW-1:0]      r_rem;
    logic [KEY_W+31:0]  product;
    logic [KEY_W-1:0]   quo;
    logic [KEY_W-1:0]   rem_full;

    // quotient from the registered key, then remainder from the registered quotient
    always_comb begin
        product  = (KEY_W+32)'(r_key) * (KEY_W+32)'(RECIP);
        quo      = KEY_W'(product >> SHIFT);
        rem_full = r_key - KEY_W'(r_quo * KEY_W'(TABLE_SIZE));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage1 <= 1'b0;
            r_stage2 <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_stage1 <= i_start;
            r_stage2 <= r_stage1;
            r_done   <= r_stage2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if (r_stage1) begin
            r_quo <= quo;
        end
        if (r_stage2) begin
            r_rem <= AW'(rem_full);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* hw/rtl/lpht_mem.sv */
// slot memory: one write port, one registered read port
`default_nettype none

module lpht_mem
    import lpht_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_slot              o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_slot         i_wr_data
);

    t_slot r_mem [DEPTH];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* bench/tb_linear_probe_hash_table_core.sv */
// testbench for the linear probe hash table core: directed and random table traffic
module tb_linear_probe_hash_table_core
    import lpht_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE = 128;
    localparam int DRAIN_CYCLES = TABLE_SIZE + 64;
    localparam int RANDOM_ROUNDS = 12;
    localparam int ROUND_ITEMS = 135;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_req i_req = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    // shadow of the table contents, updated when a transaction is accepted
    logic [1:0] table_mark [TABLE_SIZE];
    logic [KEY_W-1:0] table_key [TABLE_SIZE];
    logic signed [VALUE_W-1:0] table_value [TABLE_SIZE];
    int table_live;

    t_rsp pending_rsp [$];
    int mismatch_count = 0;
    bit idle_on = 1'b1;
    int burst_left = 1;

    linear_probe_hash_table_core #(
        .TABLE_SIZE(TABLE_SIZE)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        logic [31:0] w;
        w = $urandom();
        return w[KEY_W-1:0];
    endfunction

    // first live slot holding key along its probe path, or -1
    function automatic int find_live(input logic [KEY_W-1:0] key);
        int pos;
        pos = int'(key % TABLE_SIZE);
        for (int n = 0; n < TABLE_SIZE; n++) begin
            if (table_mark[pos] == MARK_EMPTY)
                return -1;
            if (table_mark[pos] == MARK_LIVE && table_key[pos] == key)
                return pos;
            pos = (pos + 1) % TABLE_SIZE;
        end
        return -1;
    endfunction

    function automatic t_rsp apply_table_op(input t_req r);
        t_rsp rsp;
        int pos;
        int hit;
        bit placed;
        rsp.status = ST_MISSING;
        rsp.read_value = NO_VALUE;
        placed = 1'b0;
        case (r.op)
            OP_INSERT: begin
                rsp.status = ST_FULL;
                pos = int'(r.lookup_key % TABLE_SIZE);
                for (int n = 0; n < TABLE_SIZE && !placed; n++) begin
                    if (table_mark[pos] != MARK_LIVE || table_key[pos] == r.lookup_key) begin
                        if (table_mark[pos] == MARK_LIVE) begin
                            rsp.status = ST_REPLACED;
                        end else begin
                            rsp.status = ST_NEW;
                            table_live++;
                        end
                        table_mark[pos] = MARK_LIVE;
                        table_key[pos] = r.lookup_key;
                        table_value[pos] = r.new_value;
                        placed = 1'b1;
                    end else begin
                        pos = (pos + 1) % TABLE_SIZE;
                    end
                end
            end
            OP_DELETE: begin
                hit = find_live(r.lookup_key);
                if (hit >= 0) begin
                    table_mark[hit] = MARK_DELETED;
                    if (table_live > 0)
                        table_live--;
                    rsp.status = ST_DELETED;
                end
            end
            OP_SEARCH: begin
                hit = find_live(r.lookup_key);
                if (hit >= 0) begin
                    rsp.status = ST_FOUND;
                    rsp.read_value = table_value[hit];
                end
            end
            default: ;
        endcase
        rsp.entry_count = (table_live > 255) ? 8'd255 : 8'(table_live);
        return rsp;
    endfunction

    // start stays high across a burst; a gap lowers it for a random stretch
    task automatic issue_op(input logic [1:0] op, input logic [KEY_W-1:0] key,
                            input logic signed [VALUE_W-1:0] val);
        t_req r;
        r.op = op;
        r.lookup_key = key;
        r.new_value = val;
        i_req <= r;
        start <= 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        pending_rsp.push_back(apply_table_op(r));
        if (idle_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // delete every live entry; leaves a deleted mark in every slot that was live
    task automatic clear_table();
        logic [KEY_W-1:0] keys [$];
        for (int i = 0; i < TABLE_SIZE; i++)
            if (table_mark[i] == MARK_LIVE)
                keys.push_back(table_key[i]);
        foreach (keys[i])
            issue_op(OP_DELETE, keys[i], $urandom());
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("result with none expected", 32'(o_rsp.status), 32'hx);
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch("status", 32'(o_rsp.status), 32'(want.status));
                if (o_rsp.read_value !== want.read_value)
                    report_mismatch("read_value", o_rsp.read_value, want.read_value);
                if (o_rsp.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(o_rsp.entry_count),
                                    32'(want.entry_count));
            end
        end
    end

    task automatic test_basic_ops();
        issue_op(OP_SEARCH, 31'd5, 32'sd0);
        issue_op(OP_DELETE, 31'd5, 32'sd0);
        issue_op(OP_NONE, 31'h7FFF_FFFF, -32'sd1);
        issue_op(OP_INSERT, 31'd0, 32'sh7FFF_FFFF);
        issue_op(OP_INSERT, 31'h7FFF_FFFF, 32'sh8000_0000);
        // home slot taken, wraps past the end of the table
        issue_op(OP_INSERT, 31'd127, 32'sh1234_5678);
        issue_op(OP_SEARCH, 31'd127, 32'sd0);
        issue_op(OP_INSERT, 31'd0, 32'sd0);
        issue_op(OP_SEARCH, 31'd0, 32'sd0);
        issue_op(OP_SEARCH, 31'h7FFF_FFFF, 32'sd0);
    endtask

    task automatic test_collisions();
        issue_op(OP_INSERT, 31'd5, 32'sd11);
        issue_op(OP_INSERT, 31'd133, 32'sd22);
        issue_op(OP_INSERT, 31'd261, 32'sd33);
        issue_op(OP_DELETE, 31'd133, 32'sd0);
        // search steps over the deleted slot
        issue_op(OP_SEARCH, 31'd261, 32'sd0);
        // insert reuses the deleted slot while the same key is live further on
        issue_op(OP_INSERT, 31'd261, -32'sd44);
        issue_op(OP_SEARCH, 31'd261, 32'sd0);
        issue_op(OP_DELETE, 31'd261, 32'sd0);
        issue_op(OP_SEARCH, 31'd261, 32'sd0);
        issue_op(OP_DELETE, 31'd261, 32'sd0);
        issue_op(OP_SEARCH, 31'd261, 32'sd0);
        issue_op(OP_DELETE, 31'd5, 32'sd0);
        issue_op(OP_NONE, 31'd0, 32'sd0);
    endtask

    task automatic test_table_full();
        logic [KEY_W-1:0] key;
        clear_table();
        while (table_live < TABLE_SIZE)
            issue_op(OP_INSERT, rand_key(), $urandom());
        do
            key = rand_key();
        while (find_live(key) >= 0);
        issue_op(OP_INSERT, key, $urandom());
        issue_op(OP_SEARCH, key, $urandom());
        issue_op(OP_DELETE, key, $urandom());
        key = table_key[$urandom_range(0, TABLE_SIZE - 1)];
        issue_op(OP_INSERT, key, $urandom());
        issue_op(OP_SEARCH, key, $urandom());
        issue_op(OP_DELETE, key, $urandom());
        do
            key = rand_key();
        while (find_live(key) >= 0);
        issue_op(OP_INSERT, key, $urandom());
        issue_op(OP_INSERT, rand_key(), $urandom());
        clear_table();
    endtask

    task automatic test_random_traffic();
        logic [KEY_W-1:0] pool [$];
        logic [KEY_W-1:0] key;
        logic [1:0] op;
        int pool_size;
        int pick;
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            idle_on = (round % 3 != 0);
            case ($urandom_range(0, 3))
                0: pool_size = 4;
                1: pool_size = 16;
                2: pool_size = 64;
                default: pool_size = 150;
            endcase
            pool.delete();
            for (int i = 0; i < pool_size; i++) begin
                key = rand_key();
                // clustered home slots build long probe chains
                if (round % 2 == 0)
                    key[6:0] = 7'($urandom_range(120, 127));
                pool.push_back(key);
            end
            for (int i = 0; i < ROUND_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    op = OP_INSERT;
                else if (pick < 70)
                    op = OP_DELETE;
                else if (pick < 95)
                    op = OP_SEARCH;
                else
                    op = OP_NONE;
                if ($urandom_range(0, 9) == 0)
                    key = rand_key();
                else
                    key = pool[$urandom_range(0, pool_size - 1)];
                issue_op(op, key, $urandom());
            end
        end
    endtask

    initial begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            table_mark[i] = MARK_EMPTY;
            table_key[i] = '0;
            table_value[i] = '0;
        end
        table_live = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_collisions();
        test_table_full();
        test_random_traffic();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
